[design/wspd_pkg.sv]
// wspd_pkg: shared constants, payload structs, controller states and datapath commands
// for the wheel speed pid drive block. No dependencies.
package wspd_pkg;

   localparam int PERIOD_WINDOW  = 4;
   localparam int PULSES_PER_REV = 20;
   localparam int USED_WINDOW    = (PERIOD_WINDOW < 4) ? PERIOD_WINDOW : 4;

   localparam int PERIOD_W = 24;
   localparam int CNT_W    = $clog2(USED_WINDOW + 1);
   localparam int SUM_W    = PERIOD_W + $clog2(USED_WINDOW);

   // floor(a / (p * b)) equals floor(floor(a / p) / b), so one constant numerator suffices
   localparam longint SPEED_NUM = 360000000;
   localparam longint SPEED_K   = SPEED_NUM / PULSES_PER_REV;
   localparam int     SPEED_K_W = $clog2(SPEED_K + 1);
   localparam int     DIV_W     = (SUM_W > SPEED_K_W) ? SUM_W : SPEED_K_W;
   localparam int     DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int SPEED_W     = 16;
   localparam int SPEED_MAX   = 32767;
   localparam int ERR_W       = SPEED_W + 1;
   localparam int DERR_W      = ERR_W + 1;
   localparam int GAIN_W      = 16;
   localparam int PROD_W      = GAIN_W + 1 + DERR_W;
   localparam int DRIVE_W     = 24;
   localparam int FRAC_W      = 8;
   localparam int INTEG_W     = 32;
   localparam int ISUM_W      = PROD_W + 1;
   localparam int U_W         = PROD_W + 2;
   localparam int DRIVE_LIMIT = 65280;
   localparam int DUTY_W      = 8;
   localparam int DUTY_MAX    = 255;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_SPEED,
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_PERIOD_MIN,
      CSR_PERIOD_MAX,
      CSR_DRIVE_ENABLE,
      CSR_INITIAL_DRIVE
   } csr_index_type;

   typedef struct packed {
      logic [PERIOD_W-1:0] period_0;
      logic [PERIOD_W-1:0] period_1;
      logic [PERIOD_W-1:0] period_2;
      logic [PERIOD_W-1:0] period_3;
      logic                new_samples;
      logic                stalled;
      logic                restart;
   } req_payload_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] measured_speed;
      logic [DUTY_W-1:0]         duty;
      logic                      moving;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [SPEED_W-1:0] set_speed;
      logic [GAIN_W-1:0]         gain_p;
      logic [GAIN_W-1:0]         gain_i;
      logic [GAIN_W-1:0]         gain_d;
      logic [PERIOD_W-1:0]       period_min;
      logic [PERIOD_W-1:0]       period_max;
      logic                      drive_enable;
      logic [DUTY_W-1:0]         initial_drive;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_QUAL,
      ST_SEL,
      ST_DIV_AVG,
      ST_DIV_SPEED,
      ST_PID_P,
      ST_PID_D,
      ST_PID_I,
      ST_PID_INT,
      ST_PID_SUM,
      ST_RESULT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_QUAL,
      OP_STALL,
      OP_SPEED_ZERO,
      OP_DIV_AVG,
      OP_DIV_SPEED,
      OP_SPEED_SET,
      OP_PID_P,
      OP_PID_D,
      OP_PID_I,
      OP_PID_INT,
      OP_PID_SUM,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic fresh;
      logic stall;
      logic cnt_zero;
      logic div_done;
      logic drive_enable;
   } dp_status_type;

endpackage

[design/wspd_div.sv]
// wspd_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on wspd_pkg for DIV_W and DIV_CNT_W.
module wspd_div import wspd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIV_W-1:0]     dsr_ff, dsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W:0]       trial;
   logic [DIV_W+1:0]     diff;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, dsr_ff};
   assign fits  = ~diff[DIV_W+1];

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = DIV_CNT_W'(DIV_W);
      end else if (cnt_ff != '0) begin
         // a zero divisor yields all ones, which later saturates the speed
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

[design/wspd_dp.sv]
// wspd_dp: configuration registers, period averaging, speed estimate, pid accumulators
// and result register. Depends on wspd_pkg and wspd_div.
module wspd_dp import wspd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  req_payload_type       req_data,
   input  dp_cmd_type            cmd,
   output dp_status_type         status,
   output rsp_payload_type       rsp_data
);

   localparam logic signed [U_W-1:0]     U_HI = U_W'(DRIVE_LIMIT);
   localparam logic signed [U_W-1:0]     U_LO = -U_HI;
   localparam logic signed [DRIVE_W-1:0] D_HI = DRIVE_W'(DRIVE_LIMIT);
   localparam logic signed [DRIVE_W-1:0] D_LO = -D_HI;
   localparam logic signed [ISUM_W-1:0]  I_HI = ISUM_W'((longint'(1) << (INTEG_W - 1)) - 1);
   localparam logic signed [ISUM_W-1:0]  I_LO = -I_HI - ISUM_W'(1);

   cfg_type                    cfg_ff, cfg_in;
   req_payload_type            item_ff, item_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic signed [DRIVE_W-1:0]  drive_ff, drive_in;
   logic signed [INTEG_W-1:0]  integ_ff, integ_in;
   logic signed [ERR_W-1:0]    last_err_ff, last_err_in;
   logic signed [SPEED_W-1:0]  speed_ff, speed_in;
   logic                       moving_ff, moving_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [U_W-1:0]      u_ff, u_in;
   rsp_payload_type            rsp_ff, rsp_in;

   logic [PERIOD_W-1:0]        periods [4];
   logic [SUM_W-1:0]           qual_sum;
   logic [CNT_W-1:0]           qual_cnt;
   logic                       reverse;
   logic signed [DRIVE_W-1:0]  restart_drive;
   logic signed [ERR_W-1:0]    err;
   logic signed [DERR_W-1:0]   derr;
   logic signed [DERR_W-1:0]   mul_a;
   logic [GAIN_W-1:0]          mul_g;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ISUM_W-1:0]   isum;
   logic signed [U_W-1:0]      usum;
   logic signed [SPEED_W-1:0]  speed_mag;
   logic [DRIVE_W-1:0]         drive_abs;
   logic [DUTY_W-1:0]          mag;
   logic [DUTY_W-1:0]          duty;
   logic                       div_start;
   logic [DIV_W-1:0]           div_dividend;
   logic [DIV_W-1:0]           div_divisor;
   logic                       div_done;
   logic [DIV_W-1:0]           div_quo;

   wspd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign periods[0] = item_ff.period_0;
   assign periods[1] = item_ff.period_1;
   assign periods[2] = item_ff.period_2;
   assign periods[3] = item_ff.period_3;

   always_comb begin
      qual_sum = '0;
      qual_cnt = '0;
      for (int i = 0; i < USED_WINDOW; i++) begin
         if (periods[i] >= cfg_ff.period_min && periods[i] <= cfg_ff.period_max) begin
            qual_sum = qual_sum + SUM_W'(periods[i]);
            qual_cnt = qual_cnt + CNT_W'(1);
         end
      end
   end

   assign reverse       = cfg_ff.set_speed[SPEED_W-1];
   assign restart_drive = DRIVE_W'({cfg_ff.initial_drive, {FRAC_W{1'b0}}});

   assign err  = {cfg_ff.set_speed[SPEED_W-1], cfg_ff.set_speed} - {speed_ff[SPEED_W-1], speed_ff};
   assign derr = {err[ERR_W-1], err} - {last_err_ff[ERR_W-1], last_err_ff};

   always_comb begin
      case (cmd.op)
         OP_PID_D: begin
            mul_a = derr;
            mul_g = cfg_ff.gain_d;
         end
         OP_PID_I: begin
            mul_a = {err[ERR_W-1], err};
            mul_g = cfg_ff.gain_i;
         end
         default: begin
            mul_a = {err[ERR_W-1], err};
            mul_g = cfg_ff.gain_p;
         end
      endcase
   end

   assign prod = $signed({1'b0, mul_g}) * mul_a;
   assign isum = ISUM_W'(integ_ff) + ISUM_W'(prod_ff);
   assign usum = u_ff + U_W'(integ_ff);

   assign speed_mag = (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_W'(SPEED_MAX)
                                                    : div_quo[SPEED_W-1:0];

   // duty from the integer part of the drive magnitude, inverted when reversing, zero when the drive is disabled
   assign drive_abs = drive_ff[DRIVE_W-1] ? DRIVE_W'(-drive_ff) : DRIVE_W'(drive_ff);
   assign mag       = drive_abs[FRAC_W +: DUTY_W];
   assign duty      = !cfg_ff.drive_enable ? '0 : (reverse ? DUTY_W'(DUTY_MAX) - mag : mag);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SET_SPEED:     cfg_in.set_speed     = csr_data[SPEED_W-1:0];
            CSR_GAIN_P:        cfg_in.gain_p        = csr_data[GAIN_W-1:0];
            CSR_GAIN_I:        cfg_in.gain_i        = csr_data[GAIN_W-1:0];
            CSR_GAIN_D:        cfg_in.gain_d        = csr_data[GAIN_W-1:0];
            CSR_PERIOD_MIN:    cfg_in.period_min    = csr_data[PERIOD_W-1:0];
            CSR_PERIOD_MAX:    cfg_in.period_max    = csr_data[PERIOD_W-1:0];
            CSR_DRIVE_ENABLE:  cfg_in.drive_enable  = csr_data[0];
            CSR_INITIAL_DRIVE: cfg_in.initial_drive = csr_data[DUTY_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      item_in      = cmd.capture ? req_data : item_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      drive_in     = drive_ff;
      integ_in     = integ_ff;
      last_err_in  = last_err_ff;
      speed_in     = speed_ff;
      moving_in    = moving_ff;
      prod_in      = prod_ff;
      u_in         = u_ff;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_dividend = DIV_W'(sum_ff);
      div_divisor  = DIV_W'(cnt_ff);
      case (cmd.op)
         OP_QUAL: begin
            sum_in = qual_sum;
            cnt_in = qual_cnt;
            // restart goes ahead of the speed estimate and the pid
            if (item_ff.restart) begin
               drive_in    = reverse ? -restart_drive : restart_drive;
               integ_in    = '0;
               last_err_in = '0;
            end
         end
         OP_STALL: begin
            speed_in  = '0;
            moving_in = 1'b0;
         end
         OP_SPEED_ZERO: begin
            speed_in = '0;
         end
         OP_DIV_AVG: begin
            div_start = 1'b1;
         end
         OP_DIV_SPEED: begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(SPEED_K);
            div_divisor  = div_quo;
         end
         OP_SPEED_SET: begin
            speed_in  = reverse ? -speed_mag : speed_mag;
            moving_in = 1'b1;
         end
         OP_PID_P: begin
            prod_in = prod;
         end
         OP_PID_D: begin
            u_in    = U_W'(drive_ff) + U_W'(prod_ff);
            prod_in = prod;
         end
         OP_PID_I: begin
            u_in        = u_ff + U_W'(prod_ff);
            prod_in     = prod;
            last_err_in = err;
         end
         OP_PID_INT: begin
            if (isum > I_HI) begin
               integ_in = I_HI[INTEG_W-1:0];
            end else if (isum < I_LO) begin
               integ_in = I_LO[INTEG_W-1:0];
            end else begin
               integ_in = isum[INTEG_W-1:0];
            end
         end
         OP_PID_SUM: begin
            if (usum > U_HI) begin
               drive_in = D_HI;
            end else if (usum < U_LO) begin
               drive_in = D_LO;
            end else begin
               drive_in = usum[DRIVE_W-1:0];
            end
         end
         OP_RESULT: begin
            rsp_in.measured_speed = speed_ff;
            rsp_in.duty           = duty;
            rsp_in.moving         = moving_ff;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_speed     <= '0;
         cfg_ff.gain_p        <= '0;
         cfg_ff.gain_i        <= '0;
         cfg_ff.gain_d        <= '0;
         cfg_ff.period_min    <= '0;
         cfg_ff.period_max    <= '1;
         cfg_ff.drive_enable  <= 1'b0;
         cfg_ff.initial_drive <= '0;
         drive_ff             <= '0;
         integ_ff             <= '0;
         last_err_ff          <= '0;
         speed_ff             <= '0;
         moving_ff            <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         drive_ff    <= drive_in;
         integ_ff    <= integ_in;
         last_err_ff <= last_err_in;
         speed_ff    <= speed_in;
         moving_ff   <= moving_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      u_ff    <= u_in;
      rsp_ff  <= rsp_in;
   end

   assign status.fresh        = item_ff.new_samples;
   assign status.stall        = item_ff.stalled;
   assign status.cnt_zero     = (cnt_ff == '0);
   assign status.div_done     = div_done;
   assign status.drive_enable = cfg_ff.drive_enable;

   assign rsp_data = rsp_ff;

endmodule

[design/wspd_ctrl.sv]
// wspd_ctrl: sequencer for one update: qualify, two divisions and pid steps when each is needed, result.
// Depends on wspd_pkg for states, commands and status.
module wspd_ctrl import wspd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output logic          req_stall,
   output logic          rsp_valid,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;
   logic      run_pid;
   logic      skip_div;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign run_pid  = status.fresh && status.drive_enable;
   // stall, stale window or no qualified period leave the divider unused
   assign skip_div = status.stall || !status.fresh || status.cnt_zero;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_QUAL;
         end
         ST_QUAL: state_in = ST_SEL;
         ST_SEL: begin
            if (skip_div) begin
               state_in = run_pid ? ST_PID_P : ST_RESULT;
            end else begin
               state_in = ST_DIV_AVG;
            end
         end
         ST_DIV_AVG: begin
            if (status.div_done) state_in = ST_DIV_SPEED;
         end
         ST_DIV_SPEED: begin
            if (status.div_done) state_in = run_pid ? ST_PID_P : ST_RESULT;
         end
         ST_PID_P:   state_in = ST_PID_D;
         ST_PID_D:   state_in = ST_PID_I;
         ST_PID_I:   state_in = ST_PID_INT;
         ST_PID_INT: state_in = ST_PID_SUM;
         ST_PID_SUM: state_in = ST_RESULT;
         ST_RESULT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.op      = OP_NONE;
      case (state_ff)
         ST_QUAL: cmd.op = OP_QUAL;
         ST_SEL: begin
            if (status.stall) begin
               cmd.op = OP_STALL;
            end else if (!status.fresh) begin
               cmd.op = OP_NONE;
            end else if (status.cnt_zero) begin
               cmd.op = OP_SPEED_ZERO;
            end else begin
               cmd.op = OP_DIV_AVG;
            end
         end
         ST_DIV_AVG: begin
            if (status.div_done) cmd.op = OP_DIV_SPEED;
         end
         ST_DIV_SPEED: begin
            if (status.div_done) cmd.op = OP_SPEED_SET;
         end
         ST_PID_P:   cmd.op = OP_PID_P;
         ST_PID_D:   cmd.op = OP_PID_D;
         ST_PID_I:   cmd.op = OP_PID_I;
         ST_PID_INT: cmd.op = OP_PID_INT;
         ST_PID_SUM: cmd.op = OP_PID_SUM;
         ST_RESULT: begin
            if (rsp_free) cmd.op = OP_RESULT;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      if (cmd.op == OP_RESULT) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[design/wheel_speed_pid_drive.sv]
// wheel_speed_pid_drive: one wheel speed estimate and incremental pid duty drive.
// An input transfer passes through qualify and select, then the two divisions and the pid
// steps when each is needed, and then the result register.
// A new item is taken only once the last one's result is registered; a result stall delays that.
// Reset (synchronous): pid state, speed, configuration and valid cleared, period_max all ones.
// Depends on wspd_pkg, wspd_ctrl, wspd_dp.
module wheel_speed_pid_drive import wspd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   wspd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (dp_status),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .cmd       (dp_cmd)
   );

   wspd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (dp_cmd),
      .status    (dp_status),
      .rsp_data  (rsp_data)
   );

   // one item at a time: a transfer is followed by a stall of the input
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input transfer taken while an item is in progress");

   // speed saturates symmetrically, never the most negative code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.measured_speed != {1'b1, {(SPEED_W-1){1'b0}}}))
      else $error("measured speed outside the saturation range");

   // the divider has finished whenever a new item can be taken
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> dp_status.div_done)
      else $error("divider still busy while ready for input");

endmodule

[bench/tb_top.sv]
// tb_top: self-checking bench for wheel_speed_pid_drive, random and directed windows
// checked against an in-bench speed estimate and incremental pid prediction.
// Depends on wspd_pkg and the wheel_speed_pid_drive rtl.
`timescale 1ns / 1ps

module tb_top;
   import wspd_pkg::*;

   localparam int     WINDOW_USED   = 4;
   localparam longint WHEEL_PULSES  = 20;
   localparam longint TACH_NUM      = 360000000;
   localparam longint SPEED_CAP     = 32767;
   localparam longint DRIVE_CAP     = 65280;
   localparam longint INTEG_HI      = 64'sd2147483647;
   localparam longint INTEG_LO      = -64'sd2147483648;
   localparam int     CYCLE_LIMIT   = 900000;
   localparam int     MAX_PRINTED   = 40;
   localparam int     PERIOD_ONES   = 24'hFFFFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_data;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   wheel_speed_pid_drive u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // shadow registers and controller state
   cfg_type shadow_cfg;
   longint  drive_q8   = 0;
   longint  integ_q8   = 0;
   longint  prev_err   = 0;
   longint  speed_now  = 0;
   bit      moving_now = 1'b0;

   req_payload_type pending_windows[$];
   rsp_payload_type expected_readings[$];
   int  mismatch_count = 0;
   int  cycle_count = 0;
   int  idle_pct = 27;
   bit  req_fire = 1'b0;
   rsp_payload_type want;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_range(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic rsp_payload_type predict_update(req_payload_type w);
      logic [PERIOD_W-1:0] periods [4];
      longint target, gp, gi, gd, sum, cnt, q, err, u, mag;
      bit reverse;
      int i;
      rsp_payload_type r;
      periods[0] = w.period_0;
      periods[1] = w.period_1;
      periods[2] = w.period_2;
      periods[3] = w.period_3;
      target = longint'($signed(shadow_cfg.set_speed));
      gp = longint'(shadow_cfg.gain_p);
      gi = longint'(shadow_cfg.gain_i);
      gd = longint'(shadow_cfg.gain_d);
      reverse = (target < 0);
      if (w.restart) begin
         drive_q8 = longint'(shadow_cfg.initial_drive) * 256;
         if (reverse) drive_q8 = -drive_q8;
         integ_q8 = 0;
         prev_err = 0;
      end
      if (w.stalled) begin
         speed_now = 0;
         moving_now = 1'b0;
      end else if (w.new_samples) begin
         sum = 0;
         cnt = 0;
         for (i = 0; i < WINDOW_USED; i++) begin
            if (periods[i] <= shadow_cfg.period_max && periods[i] >= shadow_cfg.period_min) begin
               sum += longint'(periods[i]);
               cnt++;
            end
         end
         speed_now = 0;
         if (cnt > 0) begin
            // an all-zero average counts as the fastest speed
            q = (sum / cnt == 0) ? SPEED_CAP : TACH_NUM / (WHEEL_PULSES * (sum / cnt));
            if (q > SPEED_CAP) q = SPEED_CAP;
            speed_now = reverse ? -q : q;
            moving_now = 1'b1;
         end
      end
      if (shadow_cfg.drive_enable) begin
         if (w.new_samples) begin
            err = target - speed_now;
            u = drive_q8 + gp * err + gd * (err - prev_err);
            prev_err = err;
            integ_q8 = clamp_range(integ_q8 + gi * err, INTEG_LO, INTEG_HI);
            u += integ_q8;
            drive_q8 = clamp_range(u, -DRIVE_CAP, DRIVE_CAP);
         end
         drive_q8 = clamp_range(drive_q8, -DRIVE_CAP, DRIVE_CAP);
         mag = ((drive_q8 < 0) ? -drive_q8 : drive_q8) / 256;
         r.duty = reverse ? DUTY_W'(255 - mag) : DUTY_W'(mag);
      end else begin
         r.duty = '0;
      end
      r.measured_speed = speed_now[SPEED_W-1:0];
      r.moving = moving_now;
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint exp_val);
      if (mismatch_count < MAX_PRINTED)
         $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                  field, got, exp_val, cycle_count);
      mismatch_count++;
   endtask

   // input side: a held item stays until its transfer
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_windows.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_data <= pending_windows.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire)
         expected_readings.push_back(predict_update(req_data));
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected result, speed", $signed(rsp_data.measured_speed), 0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_data.measured_speed !== want.measured_speed)
               report_mismatch("measured_speed", $signed(rsp_data.measured_speed),
                               $signed(want.measured_speed));
            if (rsp_data.duty !== want.duty)
               report_mismatch("duty", rsp_data.duty, want.duty);
            if (rsp_data.moving !== want.moving)
               report_mismatch("moving", rsp_data.moving, want.moving);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL wheel_speed_pid_drive");
         $finish;
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_SET_SPEED:     shadow_cfg.set_speed = val[SPEED_W-1:0];
         CSR_GAIN_P:        shadow_cfg.gain_p = val[GAIN_W-1:0];
         CSR_GAIN_I:        shadow_cfg.gain_i = val[GAIN_W-1:0];
         CSR_GAIN_D:        shadow_cfg.gain_d = val[GAIN_W-1:0];
         CSR_PERIOD_MIN:    shadow_cfg.period_min = val[PERIOD_W-1:0];
         CSR_PERIOD_MAX:    shadow_cfg.period_max = val[PERIOD_W-1:0];
         CSR_DRIVE_ENABLE:  shadow_cfg.drive_enable = val[0];
         CSR_INITIAL_DRIVE: shadow_cfg.initial_drive = val[DUTY_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(int sp, int gp, int gi, int gd, int pmin, int pmax, int en,
                            int init_drive);
      write_reg(CSR_SET_SPEED, CSR_DATA_W'(sp & 16'hFFFF));
      write_reg(CSR_GAIN_P, CSR_DATA_W'(gp));
      write_reg(CSR_GAIN_I, CSR_DATA_W'(gi));
      write_reg(CSR_GAIN_D, CSR_DATA_W'(gd));
      write_reg(CSR_PERIOD_MIN, CSR_DATA_W'(pmin));
      write_reg(CSR_PERIOD_MAX, CSR_DATA_W'(pmax));
      write_reg(CSR_DRIVE_ENABLE, CSR_DATA_W'(en));
      write_reg(CSR_INITIAL_DRIVE, CSR_DATA_W'(init_drive));
   endtask

   task automatic push_window(int p0, int p1, int p2, int p3, bit fresh, bit stall, bit rst);
      req_payload_type w;
      w.period_0 = PERIOD_W'(p0);
      w.period_1 = PERIOD_W'(p1);
      w.period_2 = PERIOD_W'(p2);
      w.period_3 = PERIOD_W'(p3);
      w.new_samples = fresh;
      w.stalled = stall;
      w.restart = rst;
      pending_windows.push_back(w);
   endtask

   // block is idle once nothing is queued, held or outstanding
   task automatic wait_drained();
      while (pending_windows.size() != 0 || req_valid || expected_readings.size() != 0)
         @(posedge clock);
   endtask

   function automatic int unsigned pick_base();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return $urandom_range(549, 1);
      if (roll < 85) return $urandom_range(60000, 550);
      return $urandom_range(PERIOD_ONES, 60001);
   endfunction

   function automatic int pick_gain();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 25) return $urandom_range(16'h40);
      if (roll < 60) return $urandom_range(16'h400);
      if (roll < 80) return $urandom_range(16'hFFFF);
      if (roll < 90) return 0;
      return 16'hFFFF;
   endfunction

   function automatic int near_period(int unsigned base);
      longint v;
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return 0;
      if (roll < 14) return PERIOD_ONES;
      if (roll < 20) return $urandom_range(PERIOD_ONES);
      v = longint'(base) + $urandom_range(base / 8) - base / 16;
      return int'(clamp_range(v, 0, PERIOD_ONES));
   endfunction

   task automatic configure_random(int unsigned base);
      int unsigned roll, nominal;
      int sp, pmin, pmax;
      longint hi;
      nominal = (18000000 / base > 32767) ? 32767 : 18000000 / base;
      roll = $urandom_range(99);
      if (roll < 60) begin
         sp = int'(clamp_range(longint'(nominal) + $urandom_range(nominal / 5) - nominal / 10,
                               0, SPEED_CAP));
         if ($urandom_range(1)) sp = -sp;
      end else if (roll < 75) begin
         sp = $urandom_range(1) ? 32767 : -32767;
      end else if (roll < 85) begin
         sp = 0;
      end else begin
         sp = int'($urandom_range(65534)) - 32767;
      end
      hi = clamp_range(longint'(base) * 2, 0, PERIOD_ONES);
      roll = $urandom_range(99);
      if (roll < 60) begin
         pmin = $urandom_range(base / 2);
         pmax = $urandom_range(PERIOD_ONES, int'(hi));
      end else if (roll < 75) begin
         pmin = 0;
         pmax = PERIOD_ONES;
      end else if (roll < 85) begin
         pmin = $urandom_range(PERIOD_ONES);
         pmax = $urandom_range(PERIOD_ONES);
      end else if (roll < 92) begin
         // inverted window: nothing qualifies
         pmin = int'(hi);
         pmax = base / 2;
      end else begin
         pmin = PERIOD_ONES;
         pmax = PERIOD_ONES;
      end
      write_all(sp, pick_gain(), pick_gain(), pick_gain(), pmin, pmax,
                ($urandom_range(99) < 85) ? 1 : 0,
                ($urandom_range(9) == 0) ? 255 * $urandom_range(1) : $urandom_range(255));
   endtask

   task automatic run_random_phase(int unsigned n_windows);
      int unsigned base, k;
      req_payload_type w;
      base = pick_base();
      configure_random(base);
      push_window(near_period(base), near_period(base), near_period(base), near_period(base),
                  1'b1, 1'b0, 1'b1);
      for (k = 1; k < n_windows; k++) begin
         if ($urandom_range(99) < 10) begin
            w.period_0 = PERIOD_W'($urandom_range(PERIOD_ONES));
            w.period_1 = PERIOD_W'($urandom_range(PERIOD_ONES));
            w.period_2 = PERIOD_W'($urandom_range(PERIOD_ONES));
            w.period_3 = PERIOD_W'($urandom_range(PERIOD_ONES));
            w.new_samples = 1'($urandom_range(1));
            w.stalled = 1'($urandom_range(1));
            w.restart = 1'($urandom_range(1));
            pending_windows.push_back(w);
         end else begin
            // the wheel speed wanders slowly, with the odd jump
            if ($urandom_range(29) == 0) base = pick_base();
            else base = int'(clamp_range(longint'(base) + $urandom_range(base / 32)
                                         - base / 64, 1, PERIOD_ONES));
            push_window(near_period(base), near_period(base), near_period(base),
                        near_period(base), $urandom_range(99) < 88, $urandom_range(99) < 5,
                        $urandom_range(99) < 3);
         end
      end
      wait_drained();
      repeat (16) @(negedge clock);
   endtask

   initial begin
      int ph;
      shadow_cfg = '0;
      shadow_cfg.period_max = '1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nominal loop, 1000 deg/s from 18000 us periods
      write_all(1000, 16'h0100, 16'h0010, 16'h0040, 0, PERIOD_ONES, 1, 100);
      push_window(18000, 18000, 18000, 18000, 1, 0, 1);
      push_window(18000, 18000, 18000, 18000, 1, 0, 0);
      push_window(0, 0, 0, 0, 1, 0, 0);
      push_window(PERIOD_ONES, PERIOD_ONES, PERIOD_ONES, PERIOD_ONES, 1, 0, 0);
      push_window(18000, 18000, 18000, 18000, 0, 0, 0);
      push_window(18000, 18000, 18000, 18000, 1, 1, 0);
      push_window(18000, 18000, 18000, 18000, 0, 1, 0);
      push_window(0, PERIOD_ONES, 1, 18000, 1, 0, 0);
      push_window(PERIOD_ONES, PERIOD_ONES, PERIOD_ONES, PERIOD_ONES, 1, 1, 1);
      wait_drained();
      repeat (16) @(negedge clock);

      // reverse, full gains, inverted window
      write_all(-32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5000, 1000, 1, 255);
      push_window(3000, 3000, 3000, 3000, 1, 0, 1);
      push_window(3000, 5000, 1000, 3000, 1, 0, 0);
      push_window(3000, 3000, 3000, 3000, 1, 0, 0);
      push_window(3000, 3000, 3000, 3000, 0, 0, 0);
      wait_drained();
      repeat (16) @(negedge clock);

      // drive disabled, restart still loads the drive
      write_all(-500, 16'h0020, 16'h0004, 16'h0008, 1000, 50000, 0, 0);
      push_window(36000, 36000, 36000, 36000, 1, 0, 1);
      push_window(500, 36000, 60000, 20000, 1, 0, 0);
      push_window(36000, 36000, 36000, 36000, 0, 0, 0);
      push_window(36000, 36000, 36000, 36000, 0, 0, 1);
      wait_drained();
      repeat (16) @(negedge clock);

      // only the longest period qualifies
      write_all(32767, 16'hFFFF, 16'hFFFF, 16'hFFFF, PERIOD_ONES, PERIOD_ONES, 1, 255);
      push_window(PERIOD_ONES, PERIOD_ONES, PERIOD_ONES, PERIOD_ONES, 1, 0, 1);
      push_window(0, 0, PERIOD_ONES, 0, 1, 0, 0);
      push_window(0, 0, 0, 0, 1, 0, 0);
      wait_drained();
      repeat (16) @(negedge clock);

      for (ph = 0; ph < 14; ph++) begin
         idle_pct = (ph == 5) ? 0 : 27;
         run_random_phase(110);
      end
      idle_pct = 27;

      wait_drained();
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS wheel_speed_pid_drive");
      end else begin
         $display("FAIL wheel_speed_pid_drive");
      end
      $finish;
   end

endmodule

[sim.f]
design/wspd_pkg.sv
design/wspd_div.sv
design/wspd_dp.sv
design/wspd_ctrl.sv
design/wheel_speed_pid_drive.sv
bench/tb_top.sv
